/* rtl/wire_plane_efficiency_counter_macros.svh */
// ----------------------------------------------------------------------------
// Wire plane efficiency counter assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef WIRE_PLANE_EFFICIENCY_COUNTER_MACROS_SVH
`define WIRE_PLANE_EFFICIENCY_COUNTER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define WPEC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpec: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define WPEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpec: next-cycle check failed");
`else
`define WPEC_ASSERT_SAME(lbl, ante, cons)
`define WPEC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/wpec_pkg.sv */
// ----------------------------------------------------------------------------
// Wire plane efficiency counter package
// Beat payload types, command codes and sequencer states.
// ----------------------------------------------------------------------------
package wpec_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_HIT  = 2'd0;
    localparam logic [1:0] MODE_EOP  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         plane;
        logic signed [15:0] wire_req;
    } wpec_cmd_t;

    typedef struct packed {
        logic        is_readout;
        logic [15:0] hit_total;
        logic [31:0] expected_count;
        logic [31:0] found_count;
    } wpec_result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIT,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_WALK_LIST,
        ST_WALK_FAR,
        ST_WALK_NEAR,
        ST_WALK_CNT,
        ST_WALK_UPD,
        ST_WIPE_LIST,
        ST_WIPE_MAP,
        ST_EOP_DONE
    } wpec_state_t;

endpackage

/* rtl/wire_plane_efficiency_counter.sv */
// ----------------------------------------------------------------------------
// Wire plane efficiency counter
// Collects a plane's hit wires, updates per-wire efficiency counters, reads them.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Beat
//  -------   ---------  ------------------------  -------------
//  command   in         start high, busy low      cmd (wpec_cmd_t)
//  result    out        done high for one cycle   result (wpec_result_t)
//
// A hit beat is stored in ST_HIT. A counter read addresses the counter in
// ST_RD_ADDR and registers its result in ST_RD_WAIT. An end-of-plane beat
// walks its L listed hits: per hit, a list read, up to two hit map reads, a
// counter read and a counter write in the counting walk, then a list read and
// a map write in the walk that wipes the hit map; the memories are single-port.
// After reset the block clears all PLANES*WIRES counter words (3200 at the
// defaults) and the hit map, and holds busy high meanwhile.
// The receiver cannot stall: done is high for exactly one cycle per result.
//
`include "wire_plane_efficiency_counter_macros.svh"

module wire_plane_efficiency_counter
    import wpec_pkg::*;
#(
    parameter int WIRES  = 400,
    parameter int PLANES = 8
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  wpec_cmd_t    cmd,
    output logic         done,
    output wpec_result_t result
);

    // Widths that follow from the plane geometry.
    localparam int WW     = $clog2(WIRES);       // wire index
    localparam int WW1    = WW + 1;              // wire index plus carry
    localparam int LW     = $clog2(WIRES + 1);   // list length, can hold WIRES
    localparam int CDEPTH = PLANES * WIRES;      // counter words
    localparam int CW     = $clog2(CDEPTH);      // counter address

    // Sequencer and bookkeeping registers.
    wpec_state_t   state_reg, state_next;
    logic [15:0]   wire_reg, wire_next;          // wire field of the held beat
    logic          read_ok_reg, read_ok_next;    // counter read in range
    logic [LW-1:0] list_len_reg, list_len_next;
    logic [LW-1:0] slots_reg, slots_next;
    logic [LW-1:0] idx_reg, idx_next;            // walk position in the list
    logic [15:0]   raw_reg, raw_next;            // saturating raw hit total
    logic [CW-1:0] clr_reg, clr_next;            // clearing pass address
    logic [CW-1:0] base_reg, base_next;          // plane base in counter memory
    logic [WW-1:0] w_reg, w_next;                // listed wire under the walk
    logic          near_reg, near_next;          // hit map bit of wire w+1
    logic          done_reg, done_next;
    wpec_result_t  result_reg, result_next;

    // Memory ports.
    logic          map_we, map_wdata, map_rdata;
    logic [WW-1:0] map_addr;
    logic          list_we;
    logic [WW-1:0] list_addr, list_wdata, list_rdata;
    logic          cnt_we;
    logic [CW-1:0] cnt_addr;
    logic [63:0]   cnt_wdata, cnt_rdata;

    // Helper terms.
    logic          accept;
    logic          in_plane_ok, in_wire_ok;
    logic [CW-1:0] in_base;
    logic          hit_wire_ok, hit_slot_ok;
    logic [WW-1:0] hit_wire;
    logic [LW-1:0] idx_inc;
    logic          walk_last;
    logic [WW:0]   far_sum;
    logic          far_ok;
    logic [WW-1:0] far_wire, near_wire;
    logic [CW-1:0] walk_addr, read_addr;
    logic [31:0]   cnt_exp, cnt_found;

    // The hit map holds one bit per wire of the plane being collected.
    wpec_ram #(
        .WIDTH (1),
        .DEPTH (WIRES)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    // The hit list keeps in-range wire numbers in arrival order.
    wpec_ram #(
        .WIDTH (WW),
        .DEPTH (WIRES)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .addr  (list_addr),
        .wdata (list_wdata),
        .rdata (list_rdata)
    );

    // Each counter word packs the expected count above the found count.
    wpec_ram #(
        .WIDTH (64),
        .DEPTH (CDEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .addr  (cnt_addr),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Range checks and the plane base are taken from the beat as it arrives.
    // Negative wire numbers have bit 15 set and so never pass the wire check.
    assign in_plane_ok = int'(cmd.plane) < PLANES;
    assign in_wire_ok  = $unsigned(cmd.wire_req) < 16'(WIRES);
    assign in_base     = CW'(int'(cmd.plane) * WIRES);

    assign hit_wire_ok = wire_reg < 16'(WIRES);
    assign hit_slot_ok = slots_reg < LW'(WIRES);
    assign hit_wire    = wire_reg[WW-1:0];

    // The walk ends on the entry whose successor index equals the length.
    assign idx_inc   = idx_reg + LW'(1);
    assign walk_last = (idx_inc == list_len_reg);

    // The hit bit of wire w+2 is used only when w+2 lies inside the plane.
    assign far_sum   = {1'b0, list_rdata} + WW1'(2);
    assign far_ok    = far_sum < WW1'(WIRES);
    assign far_wire  = far_sum[WW-1:0];
    assign near_wire = w_reg + WW'(1);

    assign walk_addr = base_reg + CW'(near_wire);
    assign read_addr = base_reg + CW'(wire_reg[WW-1:0]);

    assign cnt_exp   = cnt_rdata[63:32];
    assign cnt_found = cnt_rdata[31:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CW'(CDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.mode)
                        MODE_HIT:  state_next = ST_HIT;
                        MODE_EOP:
                        begin
                            if (list_len_reg == '0)
                            begin
                                state_next = ST_EOP_DONE;
                            end
                            else if (in_plane_ok)
                            begin
                                state_next = ST_WALK_LIST;
                            end
                            else
                            begin
                                state_next = ST_WIPE_LIST;
                            end
                        end
                        MODE_READ: state_next = ST_RD_ADDR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HIT:       state_next = ST_IDLE;
            ST_RD_ADDR:   state_next = ST_RD_WAIT;
            ST_RD_WAIT:   state_next = ST_IDLE;
            ST_WALK_LIST: state_next = ST_WALK_FAR;
            ST_WALK_FAR:
            begin
                if (far_ok)
                begin
                    state_next = ST_WALK_NEAR;
                end
                else
                begin
                    state_next = walk_last ? ST_WIPE_LIST : ST_WALK_LIST;
                end
            end
            ST_WALK_NEAR:
            begin
                if (map_rdata)
                begin
                    state_next = ST_WALK_CNT;
                end
                else
                begin
                    state_next = walk_last ? ST_WIPE_LIST : ST_WALK_LIST;
                end
            end
            ST_WALK_CNT:  state_next = ST_WALK_UPD;
            ST_WALK_UPD:  state_next = walk_last ? ST_WIPE_LIST : ST_WALK_LIST;
            ST_WIPE_LIST: state_next = ST_WIPE_MAP;
            ST_WIPE_MAP:  state_next = walk_last ? ST_EOP_DONE : ST_WIPE_LIST;
            ST_EOP_DONE:  state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory controls and the result beat for each state.
    always_comb
    begin
        map_we      = 1'b0;
        map_addr    = '0;
        map_wdata   = 1'b0;
        list_we     = 1'b0;
        list_addr   = '0;
        list_wdata  = hit_wire;
        cnt_we      = 1'b0;
        cnt_addr    = '0;
        cnt_wdata   = '0;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // One counter word and, within the plane, one map bit a cycle.
                cnt_we   = 1'b1;
                cnt_addr = clr_reg;
                map_we   = clr_reg < CW'(WIRES);
                map_addr = clr_reg[WW-1:0];
            end
            ST_HIT:
            begin
                if (hit_slot_ok && hit_wire_ok)
                begin
                    map_we    = 1'b1;
                    map_addr  = hit_wire;
                    map_wdata = 1'b1;
                    list_we   = 1'b1;
                    list_addr = list_len_reg[WW-1:0];
                end
            end
            ST_RD_ADDR:
            begin
                cnt_addr = read_addr;
            end
            ST_RD_WAIT:
            begin
                done_next                  = 1'b1;
                result_next.is_readout     = 1'b1;
                result_next.hit_total      = '0;
                result_next.expected_count = read_ok_reg ? cnt_exp : '0;
                result_next.found_count    = read_ok_reg ? cnt_found : '0;
            end
            ST_WALK_LIST, ST_WIPE_LIST:
            begin
                list_addr = idx_reg[WW-1:0];
            end
            ST_WALK_FAR:
            begin
                map_addr = far_wire;
            end
            ST_WALK_NEAR:
            begin
                map_addr = near_wire;
            end
            ST_WALK_CNT:
            begin
                cnt_addr = walk_addr;
            end
            ST_WALK_UPD:
            begin
                // Only one entry is in flight, so the read-modify-write of a
                // repeated wire always sees the previous update.
                cnt_we    = 1'b1;
                cnt_addr  = walk_addr;
                cnt_wdata = {cnt_exp + 32'd1, cnt_found + 32'(near_reg)};
            end
            ST_WIPE_MAP:
            begin
                map_we   = 1'b1;
                map_addr = list_rdata;
            end
            ST_EOP_DONE:
            begin
                done_next                  = 1'b1;
                result_next.is_readout     = 1'b0;
                result_next.hit_total      = raw_reg;
                result_next.expected_count = '0;
                result_next.found_count    = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Bookkeeping registers.
    always_comb
    begin
        wire_next     = wire_reg;
        read_ok_next  = read_ok_reg;
        list_len_next = list_len_reg;
        slots_next    = slots_reg;
        idx_next      = idx_reg;
        raw_next      = raw_reg;
        clr_next      = clr_reg;
        base_next     = base_reg;
        w_next        = w_reg;
        near_next     = near_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    wire_next    = cmd.wire_req;
                    read_ok_next = in_plane_ok && in_wire_ok;
                    base_next    = in_base;
                    idx_next     = '0;
                end
            end
            ST_HIT:
            begin
                if (raw_reg != 16'hFFFF)
                begin
                    raw_next = raw_reg + 16'd1;
                end
                if (hit_slot_ok)
                begin
                    slots_next = slots_reg + LW'(1);
                    if (hit_wire_ok)
                    begin
                        list_len_next = list_len_reg + LW'(1);
                    end
                end
            end
            ST_WALK_FAR:
            begin
                w_next = list_rdata;
                if (!far_ok)
                begin
                    idx_next = walk_last ? '0 : idx_inc;
                end
            end
            ST_WALK_NEAR:
            begin
                if (!map_rdata)
                begin
                    idx_next = walk_last ? '0 : idx_inc;
                end
            end
            ST_WALK_CNT:
            begin
                near_next = map_rdata;
            end
            ST_WALK_UPD:
            begin
                idx_next = walk_last ? '0 : idx_inc;
            end
            ST_WIPE_MAP:
            begin
                idx_next = idx_inc;
            end
            ST_EOP_DONE:
            begin
                raw_next      = '0;
                list_len_next = '0;
                slots_next    = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            list_len_reg <= '0;
            slots_reg    <= '0;
            idx_reg      <= '0;
            raw_reg      <= '0;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            list_len_reg <= list_len_next;
            slots_reg    <= slots_next;
            idx_reg      <= idx_next;
            raw_reg      <= raw_next;
            clr_reg      <= clr_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wire_reg    <= wire_next;
        read_ok_reg <= read_ok_next;
        base_reg    <= base_next;
        w_reg       <= w_next;
        near_reg    <= near_next;
        result_reg  <= result_next;
    end

    // A result beat only follows the two states that produce one.
    `WPEC_ASSERT_NEXT(a_done_source, !(state_reg == ST_RD_WAIT || state_reg == ST_EOP_DONE), !done_reg)
    // Listed hits never outnumber the slots taken.
    `WPEC_ASSERT_SAME(a_list_le_slots, 1'b1, list_len_reg <= slots_reg)
    // Slots stop at the plane's wire count.
    `WPEC_ASSERT_SAME(a_slots_bound, 1'b1, slots_reg <= LW'(WIRES))
    // The counting walk only reads the hit map.
    `WPEC_ASSERT_SAME(a_walk_no_map_write, state_reg == ST_WALK_FAR || state_reg == ST_WALK_NEAR || state_reg == ST_WALK_CNT || state_reg == ST_WALK_UPD, !map_we)
    // An accepted hit beat is stored in the following cycle.
    `WPEC_ASSERT_NEXT(a_hit_store, accept && cmd.mode == MODE_HIT, state_reg == ST_HIT)

endmodule

/* rtl/wpec_ram.sv */
// ----------------------------------------------------------------------------
// Wire plane efficiency counter RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module wpec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sim/wire_plane_efficiency_counter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wire plane efficiency counter testbench
// Drives hit, end-of-plane, counter read and unused-mode beats. It tracks
// the hit collection and the per-wire counters in a predictor of its own, and
// checks every result beat field by field against it or a pinned answer.
// ----------------------------------------------------------------------------
module wire_plane_efficiency_counter_tb;
    import wpec_pkg::*;

    localparam int WIRES        = 400;
    localparam int PLANES       = 8;
    // The longest correct stretch without any accepted beat is the clearing
    // pass after reset or a full end-of-plane walk, plus the longest sender
    // gap. The limit is several times that.
    localparam int STALL_LIMIT  = 20000;
    // A hit beat returns nothing, so a short drain after the last result is
    // enough to catch a stray one.
    localparam int DRAIN_CYCLES = 20;
    // Random beats to send after the directed table; together with the table
    // and the closing reads this comes to roughly 450 beats.
    localparam int RANDOM_BEATS = 410;
    // The mode value that the block leaves unused.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One row of the directed table. Rows with a pinned result carry the
    // answer typed in by hand; all others are checked against the predictor.
    typedef struct {
        wpec_cmd_t    beat;
        bit           pinned;
        wpec_result_t want;
    } stim_row_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         start         = 1'b0;
    wpec_cmd_t    cmd           = '0;
    logic         busy;
    logic         done;
    wpec_result_t result;

    // Side channel from the driver to the checker: the hand-typed answer of
    // the beat currently offered, if it has one.
    logic         beat_pinned   = 1'b0;
    wpec_result_t pinned_result = '0;

    // Predictor state: the hit collection of the open plane and the
    // efficiency counters of every wire of every plane.
    bit           hit_map    [WIRES];
    bit [8:0]     hit_list   [WIRES];
    int           list_len;
    int           slots_used;
    bit [15:0]    raw_hits;
    bit [31:0]    expect_cnt [PLANES*WIRES];
    bit [31:0]    found_cnt  [PLANES*WIRES];

    wpec_result_t due_results [$];
    stim_row_t    directed_rows [$];
    int           mismatches;
    int           quiet_cycles;

    wire_plane_efficiency_counter #(
        .WIRES  (WIRES),
        .PLANES (PLANES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    function automatic wpec_cmd_t make_cmd(input logic [1:0] mode, input logic [2:0] plane,
                                           input logic [15:0] wire_no);
        wpec_cmd_t c;
        c.mode     = mode;
        c.plane    = plane;
        c.wire_req = wire_no;
        return c;
    endfunction

    function automatic wpec_result_t make_result(input logic is_readout,
                                                 input logic [15:0] total,
                                                 input logic [31:0] expected,
                                                 input logic [31:0] found);
        wpec_result_t r;
        r.is_readout     = is_readout;
        r.hit_total      = total;
        r.expected_count = expected;
        r.found_count    = found;
        return r;
    endfunction

    // Applies one accepted beat to the tallies. Returns 1 when the block
    // answers the beat with a result, which is then placed in res.
    function automatic bit tally_beat(input wpec_cmd_t beat, output wpec_result_t res);
        logic [15:0] wbits;
        int unsigned w;
        int unsigned base;
        int          i;
        res   = '0;
        wbits = beat.wire_req;
        case (beat.mode)
            MODE_HIT:
            begin
                if (raw_hits != 16'hFFFF)
                    raw_hits++;
                // Only the first WIRES hit beats of a plane take a slot, and
                // only in-range wire numbers are mapped and listed.
                if (slots_used < WIRES)
                begin
                    slots_used++;
                    if (wbits < WIRES)
                    begin
                        hit_map[wbits]     = 1'b1;
                        hit_list[list_len] = wbits[8:0];
                        list_len++;
                    end
                end
                return 1'b0;
            end
            MODE_EOP:
            begin
                res.hit_total = raw_hits;
                if (beat.plane < PLANES)
                begin
                    base = beat.plane * WIRES;
                    // Every listed wire with wire+2 hit makes wire+1 an
                    // expected wire; repeated entries count every time.
                    for (i = 0; i < list_len; i++)
                    begin
                        w = hit_list[i];
                        if (w + 2 < WIRES && hit_map[w + 2])
                        begin
                            expect_cnt[base + w + 1] += 1;
                            if (hit_map[w + 1])
                                found_cnt[base + w + 1] += 1;
                        end
                    end
                end
                for (i = 0; i < list_len; i++)
                    hit_map[hit_list[i]] = 1'b0;
                list_len   = 0;
                slots_used = 0;
                raw_hits   = '0;
                return 1'b1;
            end
            MODE_READ:
            begin
                res.is_readout = 1'b1;
                if (beat.plane < PLANES && wbits < WIRES)
                begin
                    res.expected_count = expect_cnt[beat.plane * WIRES + wbits];
                    res.found_count    = found_cnt[beat.plane * WIRES + wbits];
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Results are sampled on the rising edge, before the block's own updates
    // of that edge take effect. A result beat is compared with the oldest
    // prediction first; a command beat accepted on the same edge is predicted
    // after that, so it can never be matched against its own result.
    always @(posedge clk)
    begin : result_check
        wpec_result_t got;
        wpec_result_t want;
        wpec_result_t predicted;
        if (rst_n)
        begin
            if (done)
            begin
                got = result;
                if (due_results.size() == 0)
                    report_mismatch("result beat with no prediction waiting");
                else
                begin
                    want = due_results.pop_front();
                    if (got.is_readout !== want.is_readout)
                        report_mismatch($sformatf("is_readout %0b, predicted %0b",
                                                  got.is_readout, want.is_readout));
                    if (got.hit_total !== want.hit_total)
                        report_mismatch($sformatf("hit_total %0d, predicted %0d",
                                                  got.hit_total, want.hit_total));
                    if (got.expected_count !== want.expected_count)
                        report_mismatch($sformatf("expected_count %0d, predicted %0d",
                                                  got.expected_count, want.expected_count));
                    if (got.found_count !== want.found_count)
                        report_mismatch($sformatf("found_count %0d, predicted %0d",
                                                  got.found_count, want.found_count));
                end
            end
            if (start && !busy)
            begin
                if (tally_beat(cmd, predicted))
                    due_results = {due_results, (beat_pinned ? pinned_result : predicted)};
            end
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A hung handshake on either side ends the run here.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one beat after a hold-off of gap cycles and returns on the edge
    // that accepts it. Start stays high into the next beat when that one has
    // no hold-off, so start is never lowered and raised in one time step.
    task automatic send_beat(input wpec_cmd_t beat, input int gap, input bit pin,
                             input wpec_result_t pin_res);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= beat;
        beat_pinned   <= pin;
        pinned_result <= pin_res;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_hit(input logic [15:0] wire_no, input int gap);
        send_beat(make_cmd(MODE_HIT, 3'($urandom_range(0, 7)), wire_no), gap, 1'b0, '0);
    endtask

    task automatic send_read(input logic [2:0] plane, input logic [15:0] wire_no,
                             input int gap);
        send_beat(make_cmd(MODE_READ, plane, wire_no), gap, 1'b0, '0);
    endtask

    task automatic add_beat(input logic [1:0] mode, input logic [2:0] plane,
                            input logic [15:0] wire_no);
        stim_row_t row;
        row.beat   = make_cmd(mode, plane, wire_no);
        row.pinned = 1'b0;
        row.want   = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_pinned(input logic [1:0] mode, input logic [2:0] plane,
                              input logic [15:0] wire_no, input wpec_result_t want);
        stim_row_t row;
        row.beat   = make_cmd(mode, plane, wire_no);
        row.pinned = 1'b1;
        row.want   = want;
        directed_rows = {directed_rows, row};
    endtask

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    initial
    begin : stimulus
        int          sent;
        int          n_hits;
        int          k;
        int          n_reads;
        int unsigned span_lo;
        bit          burst;
        logic [15:0] wire_no;

        // Counters read as zero right after reset, at both corners.
        add_pinned(MODE_READ, 3'd0, 16'd0,   make_result(1'b1, 16'd0, 32'd0, 32'd0));
        add_pinned(MODE_READ, 3'd7, 16'd399, make_result(1'b1, 16'd0, 32'd0, 32'd0));
        // Wires 0 and 2 hit, so wire 1 is expected and also found. A negative
        // wire number only adds to the raw total.
        add_beat(MODE_HIT, 3'd7, 16'd0);
        add_beat(MODE_HIT, 3'd0, 16'd2);
        add_beat(MODE_HIT, 3'd5, 16'd1);
        add_beat(MODE_HIT, 3'd2, 16'hFFFF);
        add_pinned(MODE_EOP, 3'd0, 16'h8000, make_result(1'b0, 16'd4, 32'd0, 32'd0));
        add_pinned(MODE_READ, 3'd0, 16'd1,  make_result(1'b1, 16'd0, 32'd1, 32'd1));
        // Top of the plane: 397 and 399 make 398 expected; 398 itself does
        // not reach past the last wire. The wire numbers at and above WIRES,
        // and the most negative one, are out of range.
        add_beat(MODE_HIT, 3'd1, 16'd397);
        add_beat(MODE_HIT, 3'd6, 16'd399);
        add_beat(MODE_HIT, 3'd3, 16'd398);
        add_beat(MODE_HIT, 3'd4, 16'd400);
        add_beat(MODE_HIT, 3'd0, 16'h7FFF);
        add_beat(MODE_HIT, 3'd7, 16'h8000);
        add_pinned(MODE_EOP, 3'd7, 16'h7FFF, make_result(1'b0, 16'd6, 32'd0, 32'd0));
        add_pinned(MODE_READ, 3'd7, 16'd398, make_result(1'b1, 16'd0, 32'd1, 32'd1));
        add_pinned(MODE_READ, 3'd7, 16'd399, make_result(1'b1, 16'd0, 32'd0, 32'd0));
        // Wire 5 twice around wire 7: wire 6 is expected twice, never found.
        add_beat(MODE_HIT, 3'd2, 16'd5);
        add_beat(MODE_HIT, 3'd2, 16'd7);
        add_beat(MODE_HIT, 3'd2, 16'd5);
        add_pinned(MODE_EOP, 3'd3, 16'd0,  make_result(1'b0, 16'd3, 32'd0, 32'd0));
        add_pinned(MODE_READ, 3'd3, 16'd6, make_result(1'b1, 16'd0, 32'd2, 32'd0));
        // The unused mode is dropped without a result; the reads behind it
        // must still line up.
        add_beat(MODE_SPARE, 3'd5, 16'hA5A5);
        add_pinned(MODE_READ, 3'd3, 16'd400,  make_result(1'b1, 16'd0, 32'd0, 32'd0));
        add_pinned(MODE_READ, 3'd3, 16'hFFFF, make_result(1'b1, 16'd0, 32'd0, 32'd0));
        // End of a plane that saw no hits at all.
        add_pinned(MODE_EOP, 3'd2, 16'h5A5A, make_result(1'b0, 16'd0, 32'd0, 32'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_beat(directed_rows[r].beat, $urandom_range(0, 4),
                      directed_rows[r].pinned, directed_rows[r].want);

        // Random planes. Hits cluster in a narrow band of wires so that
        // neighbor triples are common, with some noise wire numbers, reads
        // mixed in, the odd unused-mode beat and now and then a plane whose
        // end is left out so that its hits run into the next plane.
        sent    = 0;
        span_lo = 0;
        while (sent < RANDOM_BEATS)
        begin
            burst   = ($urandom_range(0, 3) == 0);
            n_hits  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(0, 20);
            span_lo = $urandom_range(0, WIRES - 16);
            for (k = 0; k < n_hits; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       wire_no = 16'($urandom);
                    1:       wire_no = 16'($urandom_range(WIRES, WIRES + 3));
                    default: wire_no = 16'(span_lo + $urandom_range(0, 15));
                endcase
                send_hit(wire_no, pick_gap(burst));
                sent++;
                if ($urandom_range(0, 14) == 0)
                begin
                    send_read(3'($urandom_range(0, 7)), 16'($urandom_range(0, WIRES - 1)),
                              pick_gap(burst));
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_beat(make_cmd(MODE_SPARE, 3'($urandom_range(0, 7)), 16'($urandom)),
                          pick_gap(burst), 1'b0, '0);
            if ($urandom_range(0, 9) != 0)
            begin
                send_beat(make_cmd(MODE_EOP, 3'($urandom_range(0, 7)), 16'($urandom)),
                          pick_gap(burst), 1'b0, '0);
                sent++;
            end
            n_reads = $urandom_range(0, 3);
            for (k = 0; k < n_reads; k++)
            begin
                wire_no = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'(span_lo + $urandom_range(0, 17));
                send_read(3'($urandom_range(0, 7)), wire_no, pick_gap(burst));
                sent++;
            end
        end

        // A closing read of the last band in every plane.
        for (k = 0; k < 8; k++)
            send_read(3'(k), 16'(span_lo + $urandom_range(0, 17)), $urandom_range(0, 4));

        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/wpec_pkg.sv
rtl/wpec_ram.sv
rtl/wire_plane_efficiency_counter.sv
sim/wire_plane_efficiency_counter_tb.sv
